@@ hw/rtl/idm_pkg.sv @@
package idm_pkg;

    localparam int unsigned DW = 64;
    localparam int unsigned LW = 7;

    localparam logic [22:0] EPS_LSB   = 23'd7;
    localparam logic [21:0] AP_BRAKE  = 22'd589824;
    localparam logic [47:0] SSTAR_CAP = 48'h0100_0000_0000;
    localparam logic [56:0] Q_CAP     = 57'h100_0000;
    localparam logic [31:0] HELD_RST  = 32'd6553600;

    localparam logic [2:0] REG_DESIRED_SPEED = 3'd0;
    localparam logic [2:0] REG_TIME_HEADWAY  = 3'd1;
    localparam logic [2:0] REG_JAM_DISTANCE  = 3'd2;
    localparam logic [2:0] REG_ROOT_GAP_TERM = 3'd3;
    localparam logic [2:0] REG_MAX_ACCEL     = 3'd4;
    localparam logic [2:0] REG_COMFORT_DECEL = 3'd5;
    localparam logic [2:0] REG_BRAKE_SETTING = 3'd6;
    localparam logic [2:0] REG_SPEED_CAP     = 3'd7;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } op_t;

    typedef struct packed {
        op_t           op;
        logic [LW-1:0] len;
    } unit_req_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_TLOC,
        S_V0,
        S_RATIO,
        S_ROOT,
        S_AB,
        S_SAB,
        S_DV,
        S_DVT,
        S_TV,
        S_S1,
        S_SUM,
        S_Q,
        S_Q2,
        S_X,
        S_POW,
        S_TERM,
        S_ACC,
        S_ACT,
        S_THR,
        S_OUT
    } state_t;

endpackage

@@ hw/rtl/idm_car_following_accel_top.sv @@
// Intelligent Driver Model acceleration, one vehicle per item. Each item runs through
// a sequencer that drives one shared bit-serial unit (shift-add multiply, restoring
// divide, digit-by-digit square root). Below the desired speed a nonzero gap adds
// DELTA-1 power steps, a zero gap skips straight to the action point check, and a
// new action point adds a threshold step; the input is not ready while an item is
// in flight. Results are signed Q6.16 m/s2 in m_tdata[21:0], with the new action
// point flag in m_tuser. A negative brake_setting turns on action points with a
// brake limit of 9 m/s2.
module idm_car_following_accel_top #(
    parameter int DELTA = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // gap[26:0], speed[49:27], leader_speed[72:50], speed_factor[90:73],
    // headway_factor[108:91], rand_fraction[124:109]
    input  logic [127:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // accel[21:0]
    output logic [23:0]   m_tdata,
    // new_action[0]
    output logic          m_tuser,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_addr,
    input  logic [22:0]   cfg_wdata
);
    import idm_pkg::*;

    localparam int PW = (DELTA > 2) ? $clog2(DELTA) : 1;

    // configuration
    logic [22:0] desired_speed_reg, speed_cap_reg;
    logic [19:0] time_headway_reg, max_accel_reg, comfort_decel_reg;
    logic [21:0] jam_distance_reg, root_gap_term_reg;
    logic signed [21:0] brake_setting_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            desired_speed_reg <= 23'd1966080;
            time_headway_reg  <= 20'd98304;
            jam_distance_reg  <= 22'd131072;
            root_gap_term_reg <= 22'd0;
            max_accel_reg     <= 20'd65536;
            comfort_decel_reg <= 20'd98304;
            brake_setting_reg <= 22'sd589824;
            speed_cap_reg     <= 23'd6553600;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_DESIRED_SPEED: desired_speed_reg <= cfg_wdata;
                REG_TIME_HEADWAY:  time_headway_reg  <= cfg_wdata[19:0];
                REG_JAM_DISTANCE:  jam_distance_reg  <= cfg_wdata[21:0];
                REG_ROOT_GAP_TERM: root_gap_term_reg <= cfg_wdata[21:0];
                REG_MAX_ACCEL:     max_accel_reg     <= cfg_wdata[19:0];
                REG_COMFORT_DECEL: comfort_decel_reg <= cfg_wdata[19:0];
                REG_BRAKE_SETTING: brake_setting_reg <= cfg_wdata[21:0];
                REG_SPEED_CAP:     speed_cap_reg     <= cfg_wdata;
                default:           desired_speed_reg <= desired_speed_reg;
            endcase
        end
    end

    // latched item and intermediates
    logic [26:0] gap_reg;
    logic [22:0] v_reg, vl_reg, v0_reg;
    logic [17:0] sf_reg, hf_reg;
    logic [15:0] rnd_reg;
    logic [21:0] tloc_reg;
    logic [45:0] tmp_reg;
    logic [27:0] root_reg;
    logic [19:0] sab_reg;
    logic [44:0] dvt_reg;
    logic [28:0] tv_reg;
    logic [33:0] s1t_reg, q2_reg;
    logic [40:0] sstar_reg;
    logic [24:0] q_reg;
    logic [38:0] x_reg, p_reg;
    logic [PW-1:0] pcnt_reg;
    logic [41:0] tmag_reg;
    logic        tneg_reg;
    logic signed [31:0] want_reg, held_reg;
    logic [31:0] thr_reg;
    logic        fresh_reg;
    logic        run_reg;
    logic        m_valid_reg, m_user_reg;
    logic [21:0] m_accel_reg;

    state_t state_reg, state_next;

    // shared unit hookup
    unit_req_t     req;
    logic [DW-1:0] opa, opb, res;
    logic          start, done, compute;

    idm_arith_unit u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .req     (req),
        .opa     (opa),
        .opb     (opb),
        .done    (done),
        .res     (res)
    );

    logic        ap;
    logic [21:0] brake;
    logic [22:0] dvmag;
    logic        v_lt_vl, v_lt_v0;
    logic [24:0] v0_raw;
    logic [22:0] v0_new;
    logic signed [47:0] inner, sstar_full;
    logic signed [42:0] term;
    logic [47:0] acc_hi;
    logic signed [48:0] want_wide;
    logic signed [31:0] want_sat;
    logic signed [32:0] diff;
    logic [32:0] diff_mag;
    logic signed [31:0] out_w;

    assign ap      = brake_setting_reg[21];
    assign brake   = ap ? AP_BRAKE : brake_setting_reg;
    assign v_lt_vl = v_reg < vl_reg;
    assign v_lt_v0 = v_reg < v0_reg;
    assign dvmag   = v_lt_vl ? (vl_reg - v_reg) : (v_reg - vl_reg);
    assign v0_raw  = res[40:16];

    always_comb begin
        if (v0_raw > {2'b00, speed_cap_reg}) v0_new = speed_cap_reg;
        else                                 v0_new = v0_raw[22:0];
        if (v0_new == '0) v0_new = 23'd1;
    end

    always_comb begin
        inner = $signed({19'd0, tv_reg}) + $signed({14'd0, s1t_reg})
              + (dvt_reg == '0 ? 48'sd0
                 : (v_lt_vl ? -$signed({3'd0, dvt_reg}) : $signed({3'd0, dvt_reg})));
        if (inner < 0) inner = '0;
        sstar_full = inner + $signed({26'd0, jam_distance_reg});
        if (sstar_full > $signed(SSTAR_CAP)) sstar_full = $signed(SSTAR_CAP);
    end

    assign term = 43'sd65536 - $signed({4'd0, p_reg}) - $signed({9'd0, q2_reg});

    // floor of the signed product over 2^16, saturated to 32 bits
    always_comb begin
        if (tneg_reg) acc_hi = 48'((res + 64'd65535) >> 16);
        else          acc_hi = 48'(res >> 16);
        want_wide = tneg_reg ? -$signed({1'b0, acc_hi}) : $signed({1'b0, acc_hi});
        if (want_wide > 49'sd2147483647)       want_sat = 32'sh7FFF_FFFF;
        else if (want_wide < -49'sd2147483648) want_sat = 32'sh8000_0000;
        else                                   want_sat = want_wide[31:0];
    end

    assign diff     = $signed({want_reg[31], want_reg}) - $signed({held_reg[31], held_reg});
    assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);

    always_comb begin
        out_w = want_reg;
        if (out_w < -$signed({10'd0, brake})) out_w = -$signed({10'd0, brake});
        if (out_w > 32'sd2097151)  out_w = 32'sd2097151;
        if (out_w < -32'sd2097152) out_w = -32'sd2097152;
    end

    // per-step request to the shared unit
    always_comb begin
        req.op  = OP_MUL;
        req.len = LW'(1);
        opa     = '0;
        opb     = '0;
        compute = 1'b1;
        case (state_reg)
            S_TLOC: begin req.len = LW'(18); opa = DW'(time_headway_reg); opb = DW'(hf_reg); end
            S_V0:   begin req.len = LW'(18); opa = DW'(desired_speed_reg); opb = DW'(sf_reg); end
            S_RATIO: begin
                req.op = OP_DIV; req.len = LW'(40);
                opa = DW'({(24'(v_reg) + 24'(EPS_LSB)), 16'd0}); opb = DW'(v0_reg);
            end
            S_ROOT: begin
                req.op = OP_SQRT; req.len = LW'(28); opa = DW'({tmp_reg[39:0], 16'd0});
            end
            S_AB:   begin req.len = LW'(20); opa = DW'(max_accel_reg); opb = DW'(comfort_decel_reg); end
            S_SAB:  begin req.op = OP_SQRT; req.len = LW'(20); opa = DW'(tmp_reg[39:0]); end
            S_DV:   begin req.len = LW'(23); opa = DW'(v_reg); opb = DW'(dvmag); end
            S_DVT: begin
                req.op = OP_DIV; req.len = LW'(46);
                opa = DW'(tmp_reg); opb = DW'({sab_reg, 1'b0});
            end
            S_TV:   begin req.len = LW'(23); opa = DW'(tloc_reg); opb = DW'(v_reg); end
            S_S1:   begin req.len = LW'(22); opa = DW'(root_reg); opb = DW'(root_gap_term_reg); end
            S_Q: begin
                req.op = OP_DIV; req.len = LW'(57);
                opa = DW'({sstar_reg, 16'd0}); opb = DW'(gap_reg);
            end
            S_Q2:   begin req.len = LW'(25); opa = DW'(q_reg); opb = DW'(q_reg); end
            S_X: begin
                req.op = OP_DIV; req.len = LW'(39);
                opa = DW'({v_reg, 16'd0}); opb = DW'(v0_reg);
            end
            S_POW:  begin req.len = LW'(17); opa = DW'(p_reg); opb = DW'(x_reg[16:0]); end
            S_ACC:  begin req.len = LW'(20); opa = DW'(tmag_reg); opb = DW'(max_accel_reg); end
            S_THR: begin
                req.len = LW'(16);
                opa = DW'($unsigned(-brake_setting_reg)); opb = DW'(rnd_reg);
            end
            default: compute = 1'b0;
        endcase
    end

    assign start    = compute && !run_reg;
    assign s_tready = (state_reg == S_IDLE);

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = (s_tdata[26:0] == '0) ? S_ACT : S_TLOC;
            S_TLOC:  if (done) state_next = S_V0;
            S_V0:    if (done) state_next = S_RATIO;
            S_RATIO: if (done) state_next = S_ROOT;
            S_ROOT:  if (done) state_next = S_AB;
            S_AB:    if (done) state_next = S_SAB;
            S_SAB:   if (done) state_next = S_DV;
            S_DV:    if (done) state_next = S_DVT;
            S_DVT:   if (done) state_next = S_TV;
            S_TV:    if (done) state_next = S_S1;
            S_S1:    if (done) state_next = S_SUM;
            S_SUM:   state_next = S_Q;
            S_Q:     if (done) state_next = S_Q2;
            S_Q2:    if (done) state_next = S_X;
            S_X:     if (done) state_next = (v_lt_v0 && DELTA > 1) ? S_POW : S_TERM;
            S_POW:   if (done && (pcnt_reg + 1'b1 == PW'(DELTA - 1))) state_next = S_TERM;
            S_TERM:  state_next = S_ACC;
            S_ACC:   if (done) state_next = S_ACT;
            S_ACT:   state_next = (ap && diff_mag > {1'b0, thr_reg}) ? S_THR : S_OUT;
            S_THR:   if (done) state_next = S_OUT;
            S_OUT:   if (!m_valid_reg || m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= 1'b0;
            held_reg    <= HELD_RST;
            thr_reg     <= '0;
            m_valid_reg <= 1'b0;
            fresh_reg   <= 1'b0;
        end else begin
            if (start)     run_reg <= 1'b1;
            else if (done) run_reg <= 1'b0;
            if (state_reg == S_OUT && (!m_valid_reg || m_tready)) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_tready)                     m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: fresh_reg <= 1'b0;
                S_ACT: begin
                    if (ap && diff_mag > {1'b0, thr_reg}) begin
                        held_reg  <= want_reg;
                        fresh_reg <= 1'b1;
                    end
                end
                S_THR: if (done) thr_reg <= 32'(res[37:16]);
                default: fresh_reg <= fresh_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: if (s_tvalid) begin
                gap_reg  <= s_tdata[26:0];
                v_reg    <= s_tdata[49:27];
                vl_reg   <= s_tdata[72:50];
                sf_reg   <= s_tdata[90:73];
                hf_reg   <= s_tdata[108:91];
                rnd_reg  <= s_tdata[124:109];
                want_reg <= 32'sh8000_0000;
            end
            S_TLOC:  if (done) tloc_reg <= res[37:16];
            S_V0:    if (done) v0_reg <= v0_new;
            S_RATIO: if (done) tmp_reg <= 46'(res[39:0]);
            S_ROOT:  if (done) root_reg <= res[27:0];
            S_AB:    if (done) tmp_reg <= 46'(res[39:0]);
            S_SAB:   if (done) sab_reg <= (res[19:0] == '0) ? 20'd1 : res[19:0];
            S_DV:    if (done) tmp_reg <= res[45:0];
            S_DVT:   if (done) dvt_reg <= res[44:0];
            S_TV:    if (done) tv_reg <= res[44:16];
            S_S1:    if (done) s1t_reg <= res[49:16];
            S_SUM:   sstar_reg <= sstar_full[40:0];
            S_Q:     if (done) q_reg <= (res[56:0] > Q_CAP) ? Q_CAP[24:0] : res[24:0];
            S_Q2:    if (done) q2_reg <= res[49:16];
            S_X: if (done) begin
                x_reg    <= res[38:0];
                p_reg    <= res[38:0];
                pcnt_reg <= '0;
            end
            S_POW: if (done) begin
                p_reg    <= 39'(res[33:16]);
                pcnt_reg <= pcnt_reg + 1'b1;
            end
            S_TERM: begin
                tneg_reg <= term[42];
                tmag_reg <= term[42] ? 42'(-term) : term[41:0];
            end
            S_ACC: if (done) want_reg <= want_sat;
            S_ACT: if (ap && !(diff_mag > {1'b0, thr_reg})) want_reg <= held_reg;
            S_OUT: if (!m_valid_reg || m_tready) begin
                m_accel_reg <= out_w[21:0];
                m_user_reg  <= fresh_reg;
            end
            default: tmag_reg <= tmag_reg;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_accel_reg};
    assign m_tuser  = m_user_reg;

endmodule

@@ hw/rtl/idm_arith_unit.sv @@
module idm_arith_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  idm_pkg::unit_req_t          req,
    input  logic [idm_pkg::DW-1:0]      opa,
    input  logic [idm_pkg::DW-1:0]      opb,
    output logic                        done,
    output logic [idm_pkg::DW-1:0]      res
);
    import idm_pkg::*;

    logic [DW-1:0] acc_reg, mcand_reg, mplier_reg;
    logic [LW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    op_t           op_reg;

    logic [DW-1:0] add_a, add_b, remsh;
    logic [DW:0]   sum;
    logic          sub, ge;

    // one shared adder: accumulate for multiply, trial subtract for divide and root
    always_comb begin
        remsh = acc_reg;
        add_a = acc_reg;
        add_b = mcand_reg;
        sub   = 1'b0;
        case (op_reg)
            OP_MUL: begin
                add_a = acc_reg;
                add_b = mcand_reg;
                sub   = 1'b0;
            end
            OP_DIV: begin
                remsh = {acc_reg[DW-2:0], mplier_reg[DW-1]};
                add_a = remsh;
                add_b = mcand_reg;
                sub   = 1'b1;
            end
            OP_SQRT: begin
                remsh = {acc_reg[DW-3:0], mplier_reg[DW-1:DW-2]};
                add_a = remsh;
                add_b = {mcand_reg[DW-3:0], 2'b01};
                sub   = 1'b1;
            end
            default: begin
                add_a = acc_reg;
                add_b = mcand_reg;
                sub   = 1'b0;
            end
        endcase
        sum = {1'b0, add_a} + {1'b0, (sub ? ~add_b : add_b)} + {{DW{1'b0}}, sub};
        ge  = sum[DW];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_MUL;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.len;
                op_reg   <= req.op;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == LW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            case (req.op)
                OP_MUL: begin
                    mcand_reg  <= opa;
                    mplier_reg <= opb;
                end
                OP_DIV: begin
                    mcand_reg  <= opb;
                    mplier_reg <= opa << (LW'(DW) - req.len);
                end
                OP_SQRT: begin
                    mcand_reg  <= '0;
                    mplier_reg <= opa << (LW'(DW) - {req.len[LW-2:0], 1'b0});
                end
                default: begin
                    mcand_reg  <= opa;
                    mplier_reg <= opb;
                end
            endcase
        end else if (busy_reg) begin
            case (op_reg)
                OP_MUL: begin
                    if (mplier_reg[0]) acc_reg <= sum[DW-1:0];
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                end
                OP_DIV: begin
                    acc_reg    <= ge ? sum[DW-1:0] : remsh;
                    mplier_reg <= {mplier_reg[DW-2:0], ge};
                end
                OP_SQRT: begin
                    acc_reg    <= ge ? sum[DW-1:0] : remsh;
                    mcand_reg  <= {mcand_reg[DW-2:0], ge};
                    mplier_reg <= mplier_reg << 2;
                end
                default: begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    assign done = done_reg;

    always_comb begin
        case (op_reg)
            OP_MUL:  res = acc_reg;
            OP_DIV:  res = mplier_reg;
            OP_SQRT: res = mcand_reg;
            default: res = acc_reg;
        endcase
    end

endmodule
